// File: sv/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants for the skinned vertex transform
// Fixed-point helpers, request types and the sequencer state type.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int unsigned MaxInfl = 4;
  localparam int unsigned MvpBase = 4096;
  localparam int unsigned AddrW   = 13;
  localparam int unsigned WeightW = 17;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_VERTEX = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIN,
    ST_LOCAL,
    ST_CLIP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                action;
    logic [AddrW-1:0]    word_address;
    logic signed [31:0]  word_value;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic [31:0]         joint_ids;
    logic [WeightW-1:0]  weight_0;
    logic [WeightW-1:0]  weight_1;
    logic [WeightW-1:0]  weight_2;
    logic [WeightW-1:0]  weight_3;
  } req_t;

  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
  } res_t;

  // Rounded Q16.16 from an exact 64-bit product: floor((p + 2^15) / 2^16).
  function automatic logic signed [47:0] qround(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + 65'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647)       return 32'sh7fffffff;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

endpackage

// File: sv/svt_if.sv
// ----------------------------------------------------------------------------
// svt_req_if / svt_res_if: valid/ready channels
// Request and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface svt_req_if;
  logic          valid;
  logic          ready;
  svt_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface svt_res_if;
  logic          valid;
  logic          ready;
  svt_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/svt_ram.sv
// ----------------------------------------------------------------------------
// svt_ram: generic single-port RAM
// One address per cycle: optional write, registered read of the old data.
// ----------------------------------------------------------------------------
module svt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: sv/svt_lane.sv
// ----------------------------------------------------------------------------
// svt_lane: one multiply-accumulate lane
// Q16.16 product, rounded, registered, then added to a wide accumulator.
// ----------------------------------------------------------------------------
module svt_lane (
  input  logic               clk_i,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [49:0] acc_o
);

  logic signed [47:0] prod_q;
  logic               en_q;

  always_ff @(posedge clk_i) begin
    prod_q <= svt_pkg::qround(64'(a_i) * 64'(b_i));
    en_q   <= en_i;
    if (clr_i) begin
      acc_o <= '0;
    end else if (en_q) begin
      acc_o <= acc_o + 50'(prod_q);
    end
  end

endmodule

// File: sv/skinned_vertex_transform.sv
// ----------------------------------------------------------------------------
// skinned_vertex_transform: four-influence linear blend skinning
// Skin matrix by weighted sum of joint matrices, then position and MVP.
// ----------------------------------------------------------------------------
// Sequence: a write is taken in IDLE and leaves the block ready; a vertex runs
// SKIN (one bank read per row of each of the first INFLUENCES slots, at most
// four, then a drain), LOCAL and CLIP (one matrix pass each), then OUT.
// Throughput: one request at a time; a vertex blocks the input until its result
// is taken, including any stall on the result.
// Reset: MVP clears to zero at once; the joint table is undefined until written.
module skinned_vertex_transform #(
  parameter int unsigned JOINTS     = 256,
  parameter int unsigned INFLUENCES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  svt_req_if.sink   req_i,
  svt_res_if.source res_o
);

  localparam int unsigned JtWords = JOINTS * 4;
  localparam int unsigned JtAw    = (JtWords > 1) ? $clog2(JtWords) : 1;
  localparam int unsigned NInfl   = (INFLUENCES < svt_pkg::MaxInfl) ?
                                    INFLUENCES : svt_pkg::MaxInfl;

  svt_pkg::state_e    state_q, state_d;
  svt_pkg::req_t      req_q;
  logic [1:0]         k_q, k_d;     // influence
  logic [1:0]         r_q, r_d;     // row
  logic [2:0]         tail_q, tail_d;
  logic signed [31:0] skin_q [16];
  logic signed [31:0] loc_q  [4];
  logic signed [31:0] clip_q [4];
  logic signed [31:0] mvp_q  [16];

  logic        accept;
  logic        wr_joint;
  logic        mvp_hit;
  logic [12:0] wa;
  assign accept   = req_i.valid && req_i.ready;
  assign wa       = req_i.payload.word_address;
  assign mvp_hit  = accept && req_i.payload.action == svt_pkg::ACT_WRITE
                 && wa >= 13'(svt_pkg::MvpBase) && wa < 13'(svt_pkg::MvpBase + 16);
  assign wr_joint = accept && req_i.payload.action == svt_pkg::ACT_WRITE
                 && !mvp_hit && (32'(wa) < JOINTS * 16);

  // Four banks, one per column; bank word = joint*4 + row.
  logic [JtAw-1:0]    ram_addr;
  logic signed [31:0] ram_rd [4];
  logic [7:0]         idx_k;
  logic [16:0]        w_k;
  logic               use_k;

  always_comb begin
    case (k_q)
      2'd0:    begin idx_k = req_q.joint_ids[7:0];   w_k = req_q.weight_0; end
      2'd1:    begin idx_k = req_q.joint_ids[15:8];  w_k = req_q.weight_1; end
      2'd2:    begin idx_k = req_q.joint_ids[23:16]; w_k = req_q.weight_2; end
      default: begin idx_k = req_q.joint_ids[31:24]; w_k = req_q.weight_3; end
    endcase
    use_k = (w_k != '0) && (32'(idx_k) < JOINTS);
    if (state_q == svt_pkg::ST_SKIN) begin
      ram_addr = JtAw'({32'(idx_k), r_q});
    end else begin
      ram_addr = JtAw'(wa[12:2]);
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_bank
    logic [31:0] rd;
    svt_ram #(.Width(32), .Depth(JtWords)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_joint && wa[1:0] == 2'(c)),
      .addr_i  (ram_addr),
      .wdata_i (req_i.payload.word_value),
      .rdata_o (rd)
    );
    assign ram_rd[c] = rd;
  end

  // Skin phase: delay row/weight to align with RAM read, then MAC per column.
  logic               skin_rd_q;
  logic [1:0]         r_rd_q;
  logic [16:0]        w_k_d1_q;
  logic               lane_clr;
  logic               lane_en [4];
  logic signed [31:0] lane_a [4], lane_b [4];
  logic signed [49:0] lane_acc [4];

  // Skin accumulators: 16 wide sums, one row per cycle across the four columns.
  logic signed [49:0] sacc_q [16];
  logic signed [47:0] sprod_q [4];
  logic               sprod_v_q;
  logic [1:0]         sprod_r_q;

  // Only the read cycles of the skin phase feed the sums, not its drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skin_rd_q <= 1'b0;
      sprod_v_q <= 1'b0;
    end else begin
      skin_rd_q <= (state_q == svt_pkg::ST_SKIN) && (tail_q == 3'd4) && use_k;
      sprod_v_q <= skin_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_rd_q   <= r_q;
    w_k_d1_q <= w_k;
    for (int c = 0; c < 4; c++) begin
      sprod_q[c] <= svt_pkg::qround(64'($signed({15'd0, w_k_d1_q})) * 64'(ram_rd[c]));
    end
    sprod_r_q <= r_rd_q;
    if (accept) begin
      for (int i = 0; i < 16; i++) sacc_q[i] <= '0;
    end else if (sprod_v_q) begin
      for (int c = 0; c < 4; c++) begin
        sacc_q[{sprod_r_q, 2'(c)}] <= sacc_q[{sprod_r_q, 2'(c)}] + 50'(sprod_q[c]);
      end
    end
  end

  // Matrix-vector phases: lane c handles output row c, one column per cycle.
  logic [1:0] col;
  assign lane_clr = (state_q != svt_pkg::ST_LOCAL && state_q != svt_pkg::ST_CLIP)
                    || tail_q == 3'd7;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      lane_en[c] = (tail_q < 3'd4);
      if (state_q == svt_pkg::ST_LOCAL) begin
        lane_a[c] = skin_q[{2'(c), col}];
        case (col)
          2'd0:    lane_b[c] = req_q.pos_x;
          2'd1:    lane_b[c] = req_q.pos_y;
          2'd2:    lane_b[c] = req_q.pos_z;
          default: lane_b[c] = 32'sd65536;
        endcase
      end else begin
        lane_a[c] = mvp_q[{2'(c), col}];
        lane_b[c] = loc_q[col];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    svt_lane u_lane (
      .clk_i (clk_i),
      .clr_i (lane_clr),
      .en_i  (lane_en[c] && (state_q == svt_pkg::ST_LOCAL || state_q == svt_pkg::ST_CLIP)),
      .a_i   (lane_a[c]),
      .b_i   (lane_b[c]),
      .acc_o (lane_acc[c])
    );
  end
  assign col = tail_q[1:0];

  // Sequencer: SKIN reads each row of each influence slot, then drains; LOCAL and CLIP run one matrix pass each.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    r_d     = r_q;
    tail_d  = tail_q;
    unique case (state_q)
      svt_pkg::ST_IDLE: begin
        k_d = '0; r_d = '0; tail_d = '0;
        if (accept && req_i.payload.action == svt_pkg::ACT_VERTEX) begin
          state_d = svt_pkg::ST_SKIN;
          tail_d  = 3'd4;
        end
      end
      svt_pkg::ST_SKIN: begin
        if (tail_q == 3'd4) begin
          r_d = r_q + 2'd1;
          if (r_q == 2'd3) begin
            if (32'(k_q) == NInfl - 1) tail_d = 3'd0;
            else k_d = k_q + 2'd1;
          end
        end else if (tail_q == 3'd3) begin
          state_d = svt_pkg::ST_LOCAL;
          tail_d  = 3'd7;
        end else begin
          tail_d = tail_q + 3'd1;
        end
      end
      svt_pkg::ST_LOCAL, svt_pkg::ST_CLIP: begin
        tail_d = tail_q + 3'd1;
        if (tail_q == 3'd6) begin
          tail_d  = 3'd7;
          state_d = (state_q == svt_pkg::ST_LOCAL) ? svt_pkg::ST_CLIP : svt_pkg::ST_OUT;
        end
      end
      svt_pkg::ST_OUT: begin
        if (res_o.ready) state_d = svt_pkg::ST_IDLE;
      end
      default: state_d = svt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= svt_pkg::ST_IDLE;
      k_q       <= '0;
      r_q       <= '0;
      tail_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      r_q     <= r_d;
      tail_q  <= tail_d;
    end
  end

  // MVP words: zero at reset through the valid flag.
  logic signed [31:0] mvp_raw_q [16];
  logic [15:0]        mvp_wr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvp_wr_q <= '0;
    end else if (mvp_hit) begin
      mvp_wr_q[wa[3:0]] <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mvp_hit) begin
      mvp_raw_q[wa[3:0]] <= req_i.payload.word_value;
    end
  end
  always_comb begin
    for (int i = 0; i < 16; i++) mvp_q[i] = mvp_wr_q[i] ? mvp_raw_q[i] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i.payload;
    if (state_q == svt_pkg::ST_SKIN && tail_q == 3'd3) begin
      for (int i = 0; i < 16; i++) skin_q[i] <= svt_pkg::sat32(sacc_q[i]);
    end
    if (state_q == svt_pkg::ST_LOCAL && tail_q == 3'd6) begin
      for (int c = 0; c < 4; c++) loc_q[c] <= svt_pkg::sat32(lane_acc[c]);
    end
    if (state_q == svt_pkg::ST_CLIP && tail_q == 3'd6) begin
      for (int c = 0; c < 4; c++) clip_q[c] <= svt_pkg::sat32(lane_acc[c]);
    end
  end

  assign req_i.ready           = (state_q == svt_pkg::ST_IDLE);
  assign res_o.valid           = (state_q == svt_pkg::ST_OUT);
  assign res_o.payload.clip_x  = clip_q[0];
  assign res_o.payload.clip_y  = clip_q[1];
  assign res_o.payload.clip_z  = clip_q[2];
  assign res_o.payload.clip_w  = clip_q[3];

  // Assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != svt_pkg::ST_IDLE |-> !req_i.ready) else $error("accept while busy");
  a_out_from_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q) == svt_pkg::ST_CLIP) else $error("bad result path");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.payload))
    else $error("result dropped");
  a_skin_mac_in_skin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sprod_v_q |-> state_q == svt_pkg::ST_SKIN) else $error("skin sum late");

endmodule
